FILE: rtl/client_table_with_aging_fanout_defines.svh
// assertion macros for the client table block
`ifndef CLIENT_TABLE_WITH_AGING_FANOUT_DEFINES_SVH
`define CLIENT_TABLE_WITH_AGING_FANOUT_DEFINES_SVH

`ifndef SYNTH
`define CTAF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CTAF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CTAF_ASSERT_SAME(lbl, ante, cons, msg)
`define CTAF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/ctaf_pkg.sv
package ctaf_pkg;

    localparam int MAX_CLIENTS = 16;
    localparam int IDX_W       = $clog2(MAX_CLIENTS);
    localparam int CNT_W       = $clog2(MAX_CLIENTS + 1);
    localparam int ADDR_W      = 32;
    localparam int TIME_W      = 32;
    localparam int TMO_W       = 16;
    localparam int ENTRY_W     = ADDR_W + TIME_W;

    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd30;

    typedef struct packed {
        logic load;
        logic rd_first;
        logic rd_next;
        logic set_hit;
        logic update;
        logic walk_init;
        logic keep;
        logic finish;
    } ctaf_cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic match;
        logic at_last;
        logic live;
        logic pend_valid;
        logic out_free;
    } ctaf_status_t;

endpackage

FILE: rtl/ctaf_in_if.sv
interface ctaf_in_if
    import ctaf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] source_addr;
    logic [TIME_W-1:0] now_seconds;

    modport source (output valid, output source_addr, output now_seconds, input ready);
    modport sink   (input valid, input source_addr, input now_seconds, output ready);
endinterface

FILE: rtl/ctaf_out_if.sv
interface ctaf_out_if
    import ctaf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] dest_addr;
    logic              dest_valid;
    logic              sender_dropped;
    logic              last_of_run;

    modport source (output valid, output dest_addr, output dest_valid,
                    output sender_dropped, output last_of_run, input ready);
    modport sink   (input valid, input dest_addr, input dest_valid,
                    input sender_dropped, input last_of_run, output ready);
endinterface

FILE: rtl/client_table_with_aging_fanout.sv
// client table with aging and fan-out
// in_ch carries one beat per arriving message: sender address and time in seconds.
// each input beat is looked up in an insertion-ordered table of up to 16 clients;
// a hit refreshes the entry's time, a miss appends it or flags sender_dropped if full.
// the table is then walked in order: stale entries are removed and the rest close up,
// and every live entry leaves on out_ch as one beat, last_of_run on the final one.
// with no live entry a single beat with dest_valid low and last_of_run high is sent.
// the lookup reads one table word per cycle, and so does the walk while out_ch
// is not stalled; the table memory has one read port and one write port.
// a new beat is taken only once the previous item's last result is in the output
// register, so in_ch.ready is high only between items.
// a stalled out_ch holds its beat and pauses the walk, once a further beat is due, until it is taken.
// reset empties the table, sets the timeout to 30 s and drops any pending beat.
// cfg_wr_en with cfg_wr_data writes the timeout; write it only between items.
`include "client_table_with_aging_fanout_defines.svh"

module client_table_with_aging_fanout
    import ctaf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    ctaf_in_if.sink          in_ch,
    ctaf_out_if.source       out_ch,
    input  logic             cfg_wr_en,
    input  logic [TMO_W-1:0] cfg_wr_data
);
    ctaf_cmd_t    cmd;
    ctaf_status_t status;

    ctaf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    ctaf_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_source_addr (in_ch.source_addr),
        .in_now_seconds (in_ch.now_seconds),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .cmd            (cmd),
        .status         (status),
        .out_ch         (out_ch)
    );

    `CTAF_ASSERT_NEXT(a_one_item_at_a_time, in_ch.valid && in_ch.ready, !in_ch.ready, "input taken twice in a row")
    `CTAF_ASSERT_SAME(a_mid_run_has_dest, out_ch.valid && !out_ch.last_of_run, out_ch.dest_valid, "non-final beat without destination")
    `CTAF_ASSERT_SAME(a_empty_is_last, out_ch.valid && !out_ch.dest_valid, out_ch.last_of_run, "empty beat not marked last")
    `CTAF_ASSERT_SAME(a_accept_after_run, in_ch.valid && in_ch.ready, !(out_ch.valid && !out_ch.last_of_run), "input taken while run unfinished")
endmodule

FILE: rtl/ctaf_ram.sv
module ctaf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

FILE: rtl/ctaf_ctrl.sv
module ctaf_ctrl
    import ctaf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  ctaf_status_t status,
    output ctaf_cmd_t    cmd
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOOK = 3'd1;
    localparam logic [2:0] ST_UPD  = 3'd2;
    localparam logic [2:0] ST_WST  = 3'd3;
    localparam logic [2:0] ST_WALK = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       advance;

    assign in_ready = (state_reg == ST_IDLE);
    assign advance  = !(status.live && status.pend_valid) || status.out_free;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.cnt_zero)
                    begin
                        state_next = ST_UPD;
                    end
                    else
                    begin
                        cmd.rd_first = 1'b1;
                        state_next   = ST_LOOK;
                    end
                end
            end
            ST_LOOK:
            begin
                if (status.match)
                begin
                    cmd.set_hit = 1'b1;
                    state_next  = ST_UPD;
                end
                else if (status.at_last)
                begin
                    state_next = ST_UPD;
                end
                else
                begin
                    cmd.rd_next = 1'b1;
                end
            end
            ST_UPD:
            begin
                cmd.update = 1'b1;
                state_next = ST_WST;
            end
            ST_WST:
            begin
                cmd.rd_first  = 1'b1;
                cmd.walk_init = 1'b1;
                state_next    = ST_WALK;
            end
            ST_WALK:
            begin
                if (advance)
                begin
                    cmd.keep = status.live;
                    if (status.at_last)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                    end
                end
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

FILE: rtl/ctaf_datapath.sv
module ctaf_datapath
    import ctaf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [ADDR_W-1:0] in_source_addr,
    input  logic [TIME_W-1:0] in_now_seconds,
    input  logic              cfg_wr_en,
    input  logic [TMO_W-1:0]  cfg_wr_data,
    input  ctaf_cmd_t         cmd,
    output ctaf_status_t      status,
    ctaf_out_if.source        out_ch
);
    logic [ADDR_W-1:0]  src_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [TMO_W-1:0]   timeout_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [CNT_W-1:0]   kept_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               hit_reg;
    logic               full_reg;
    logic [ADDR_W-1:0]  pend_reg;
    logic               pend_valid_reg;

    logic               out_valid_reg;
    logic [ADDR_W-1:0]  out_addr_reg;
    logic               out_dvalid_reg;
    logic               out_drop_reg;
    logic               out_last_reg;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [ADDR_W-1:0]  rd_addr;
    logic [TIME_W-1:0]  rd_ts;
    logic [TIME_W-1:0]  age;
    logic               appending;
    logic               dropped;
    logic               push;
    logic [ADDR_W-1:0]  push_addr;
    logic               push_dvalid;
    logic               push_last;

    ctaf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_CLIENTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_addr   = ram_rdata[ENTRY_W-1 -: ADDR_W];
    assign rd_ts     = ram_rdata[TIME_W-1:0];
    assign age       = now_reg - rd_ts;
    assign appending = !hit_reg && !full_reg;
    assign dropped   = full_reg && !hit_reg;

    assign ram_re    = cmd.rd_first || cmd.rd_next;
    assign ram_raddr = cmd.rd_first ? '0 : idx_reg + 1'b1;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = {src_reg, now_reg};
        if (cmd.update)
        begin
            ram_we    = hit_reg || !full_reg;
            ram_waddr = hit_reg ? idx_reg : cnt_reg[IDX_W-1:0];
        end
        else if (cmd.keep)
        begin
            ram_we    = 1'b1;
            ram_waddr = kept_reg[IDX_W-1:0];
            ram_wdata = ram_rdata;
        end
    end

    // results: hold back one kept entry so the last one can be marked
    always_comb
    begin
        push        = 1'b0;
        push_addr   = pend_reg;
        push_dvalid = 1'b1;
        push_last   = 1'b0;
        if (cmd.keep && pend_valid_reg)
        begin
            push = 1'b1;
        end
        else if (cmd.finish)
        begin
            push        = 1'b1;
            push_addr   = pend_valid_reg ? pend_reg : '0;
            push_dvalid = pend_valid_reg;
            push_last   = 1'b1;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.update && appending)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (cmd.finish)
        begin
            cnt_next = kept_reg;
        end
    end

    assign status.cnt_zero   = (cnt_reg == '0);
    assign status.match      = (rd_addr == src_reg);
    assign status.at_last    = ({1'b0, idx_reg} + 1'b1) == cnt_reg;
    assign status.live       = age <= {{(TIME_W-TMO_W){1'b0}}, timeout_reg};
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= TIMEOUT_RESET;
            cnt_reg        <= '0;
            kept_reg       <= '0;
            hit_reg        <= 1'b0;
            full_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
            cnt_reg <= cnt_next;
            if (cmd.load)
            begin
                hit_reg  <= 1'b0;
                full_reg <= (cnt_reg == CNT_W'(MAX_CLIENTS));
            end
            if (cmd.set_hit)
            begin
                hit_reg <= 1'b1;
            end
            if (cmd.walk_init)
            begin
                kept_reg       <= '0;
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.keep)
            begin
                kept_reg       <= kept_reg + 1'b1;
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.finish)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            src_reg <= in_source_addr;
            now_reg <= in_now_seconds;
        end
        if (cmd.rd_first)
        begin
            idx_reg <= '0;
        end
        else if (cmd.rd_next)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.keep)
        begin
            pend_reg <= rd_addr;
        end
        if (push)
        begin
            out_addr_reg   <= push_addr;
            out_dvalid_reg <= push_dvalid;
            out_drop_reg   <= dropped;
            out_last_reg   <= push_last;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.dest_addr      = out_addr_reg;
    assign out_ch.dest_valid     = out_dvalid_reg;
    assign out_ch.sender_dropped = out_drop_reg;
    assign out_ch.last_of_run    = out_last_reg;
endmodule
